[design/wth_pkg.sv]
`timescale 1ns / 1ps

package wth_pkg;

    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int NBINS_W   = 11;
    localparam int BIN_OUT_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = TIME_W + NBINS_W;
    localparam int DIV_STEPS = NBINS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [NBINS_W-1:0]   t_nbins;
    typedef logic [BIN_OUT_W-1:0] t_bin_out;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WINDOW_START = 2'd0;
    localparam t_cfg_idx CFG_WINDOW_END   = 2'd1;
    localparam t_cfg_idx CFG_BINS_IN_USE  = 2'd2;

    localparam t_time  RST_WINDOW_START = 48'd0;
    localparam t_time  RST_WINDOW_END   = 48'd65536;
    localparam t_nbins RST_BINS_IN_USE  = 11'd1024;

    localparam t_count COUNT_MAX = '1;

endpackage

[design/wth_ram.sv]
`timescale 1ns / 1ps

module wth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/wth_bin_unit.sv]
`timescale 1ns / 1ps

module wth_bin_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  wth_pkg::t_time  i_offset,
    input  wth_pkg::t_time  i_span,
    input  wth_pkg::t_nbins i_nbins,
    output logic            o_done,
    output wth_pkg::t_nbins o_bin
);

    import wth_pkg::*;

    logic              r_act;
    logic              r_mul_pend;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_time             r_offset;
    t_time             r_span;
    t_nbins            r_n;
    t_time             r_rem;
    t_nbins            r_q;

    logic [PROD_W-1:0] prod;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              ge;

    assign prod  = PROD_W'(r_offset) * PROD_W'(r_n);
    assign trial = {r_rem, r_q[NBINS_W-1]};
    assign ge    = trial >= {1'b0, r_span};
    assign diff  = trial - {1'b0, r_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_mul_pend <= 1'b0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_act      <= 1'b1;
                r_mul_pend <= 1'b1;
            end else if (r_mul_pend) begin
                r_mul_pend <= 1'b0;
                r_cnt      <= STEP_W'(DIV_STEPS);
            end else if (r_act) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_offset <= i_offset;
            r_span   <= i_span;
            r_n      <= i_nbins;
        end else if (r_mul_pend) begin
            // quotient < 2^NBINS_W, so the upper part starts below the divisor
            r_rem <= prod[PROD_W-1:NBINS_W];
            r_q   <= prod[NBINS_W-1:0];
        end else if (r_act) begin
            r_rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            r_q   <= {r_q[NBINS_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_bin  = (r_q >= r_n) ? (r_n - 1'b1) : r_q;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_act && !r_mul_pend)
        else $error("bin unit done while still running");
    a_mul_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |=> r_mul_pend && r_act)
        else $error("bin unit did not start with multiply");
`endif

endmodule

[design/windowed_time_histogram.sv]
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// input    | start, busy           | i_mode, i_event_time, i_read_bin
// result   | o_done (1-cycle beat) | o_in_window, o_bin_index, o_bin_count,
//          |                       | o_peak_count, o_total_count
// config   | i_cfg_we              | i_cfg_index, i_cfg_wdata
//
// Accumulate beat in window: window check, then the multiply and the 11-step
// shift-subtract divider in the bin unit, then the bin read-modify-write.
// Accumulate beat outside the window: window check only. Read beat: bin read.
// After reset a clearing pass writes every bin, with busy high.
// Busy stays high while a beat is in flight; the receiver cannot stall.

module windowed_time_histogram #(
    parameter int MAX_BINS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_mode,
    input  wth_pkg::t_time    i_event_time,
    input  wth_pkg::t_bin_out i_read_bin,
    input  logic              i_cfg_we,
    input  wth_pkg::t_cfg_idx i_cfg_index,
    input  wth_pkg::t_time    i_cfg_wdata,
    output logic              o_done,
    output logic              o_in_window,
    output wth_pkg::t_bin_out o_bin_index,
    output wth_pkg::t_count   o_bin_count,
    output wth_pkg::t_count   o_peak_count,
    output wth_pkg::t_count   o_total_count
);

    import wth_pkg::*;

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_CALC   = 6'b001000,
        S_READ   = 6'b010000,
        S_UPDATE = 6'b100000
    } t_state;

    t_state  r_state;
    logic [AW-1:0] r_clr_addr;

    t_time   r_win_start;
    t_time   r_win_end;
    t_nbins  r_bins;

    logic    r_mode;
    t_time   r_time;
    t_nbins  r_bin;
    logic    r_rd_ok;

    t_count  r_peak;
    t_count  r_total;

    logic     r_done;
    logic     r_out_win;
    t_bin_out r_out_bin;
    t_count   r_out_count;
    t_count   r_out_peak;
    t_count   r_out_total;

    logic    in_win;
    t_time   offset;
    t_time   span;
    t_nbins  n_eff;
    logic    unit_go;
    logic    unit_done;
    t_nbins  unit_bin;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_count        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_count        ram_rdata;
    t_count        inc_count;

    assign in_win = (r_win_end > r_win_start) && (r_time >= r_win_start)
                    && (r_time <= r_win_end);
    assign offset = r_time - r_win_start;
    assign span   = r_win_end - r_win_start;

    always_comb begin
        n_eff = r_bins;
        if (r_bins == '0) begin
            n_eff = NBINS_W'(1);
        end else if (32'(r_bins) > 32'(MAX_BINS)) begin
            n_eff = NBINS_W'(MAX_BINS);
        end
    end

    assign unit_go = (r_state == S_CHECK) && in_win;

    wth_bin_unit u_bin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (unit_go),
        .i_offset (offset),
        .i_span   (span),
        .i_nbins  (n_eff),
        .o_done   (unit_done),
        .o_bin    (unit_bin)
    );

    assign inc_count = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_bin);
        ram_wdata = inc_count;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == S_UPDATE && !r_mode) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = AW'(r_bin);

    wth_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= RST_WINDOW_START;
            r_win_end   <= RST_WINDOW_END;
            r_bins      <= RST_BINS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_START: r_win_start <= i_cfg_wdata;
                CFG_WINDOW_END:   r_win_end   <= i_cfg_wdata;
                CFG_BINS_IN_USE:  r_bins      <= i_cfg_wdata[NBINS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_peak     <= '0;
            r_total    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MAX_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= i_mode ? S_READ : S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (in_win) begin
                        r_state <= S_CALC;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_CALC: begin
                    if (unit_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (!r_mode) begin
                        if (inc_count > r_peak) begin
                            r_peak <= inc_count;
                        end
                        if (r_total != COUNT_MAX) begin
                            r_total <= r_total + 1'b1;
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_mode  <= i_mode;
            r_time  <= i_event_time;
            r_bin   <= {1'b0, i_read_bin};
            r_rd_ok <= (32'(i_read_bin) < 32'(MAX_BINS));
        end else if (r_state == S_CALC && unit_done) begin
            r_bin   <= unit_bin;
            r_rd_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_out_win   <= 1'b0;
            r_out_bin   <= '0;
            r_out_count <= '0;
            r_out_peak  <= r_peak;
            r_out_total <= r_total;
        end else if (r_state == S_UPDATE) begin
            r_out_bin <= r_bin[BIN_OUT_W-1:0];
            if (r_mode) begin
                r_out_win   <= 1'b0;
                r_out_count <= r_rd_ok ? ram_rdata : '0;
                r_out_peak  <= r_peak;
                r_out_total <= r_total;
            end else begin
                r_out_win   <= 1'b1;
                r_out_count <= inc_count;
                r_out_peak  <= (inc_count > r_peak) ? inc_count : r_peak;
                r_out_total <= (r_total != COUNT_MAX) ? r_total + 1'b1 : r_total;
            end
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_in_window   = r_out_win;
    assign o_bin_index   = r_out_bin;
    assign o_bin_count   = r_out_count;
    assign o_peak_count  = r_out_peak;
    assign o_total_count = r_out_total;

`ifndef NO_ASSERTIONS
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(r_state) == S_UPDATE || $past(r_state) == S_CHECK))
        else $error("result beat from unexpected state");
    a_peak_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= r_total)
        else $error("peak exceeds total");
    a_counted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_out_win |-> r_out_count != '0 && r_out_total != '0)
        else $error("counted beat with zero count");
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> busy && !r_done)
        else $error("activity during clearing pass");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import wth_pkg::*;

    localparam int    HIST_BINS    = 1024;
    localparam int    DRAIN_CYCLES = 24;
    localparam int    STALL_LIMIT  = 4000;
    localparam int    RANDOM_ITEMS = 850;
    localparam t_time T_MAX        = '1;

    typedef struct packed {
        logic     mode;
        t_time    event_time;
        t_bin_out read_bin;
    } hist_item_t;

    typedef struct packed {
        logic     in_window;
        t_bin_out bin_index;
        t_count   bin_count;
        t_count   peak_count;
        t_count   total_count;
    } hist_result_t;

    logic     i_clk        = 1'b0;
    logic     i_rst_n      = 1'b0;
    logic     start        = 1'b0;
    logic     busy;
    logic     i_mode       = 1'b0;
    t_time    i_event_time = '0;
    t_bin_out i_read_bin   = '0;
    logic     i_cfg_we     = 1'b0;
    t_cfg_idx i_cfg_index  = CFG_WINDOW_START;
    t_time    i_cfg_wdata  = '0;
    logic     o_done;
    logic     o_in_window;
    t_bin_out o_bin_index;
    t_count   o_bin_count;
    t_count   o_peak_count;
    t_count   o_total_count;

    hist_item_t   pending_events[$];
    hist_result_t predicted_results[$];

    t_count hist_bins [HIST_BINS] = '{default: '0};
    t_count hist_peak  = '0;
    t_count hist_total = '0;
    t_time  win_start  = RST_WINDOW_START;
    t_time  win_end    = RST_WINDOW_END;
    t_nbins nbins      = RST_BINS_IN_USE;

    int idle_pct     = 32;
    bit feed_hold    = 1'b1;
    int mismatch_cnt = 0;
    int stall_cnt    = 0;

    always #5 i_clk = ~i_clk;

    windowed_time_histogram #(
        .MAX_BINS(HIST_BINS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_event_time (i_event_time),
        .i_read_bin   (i_read_bin),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_in_window  (o_in_window),
        .o_bin_index  (o_bin_index),
        .o_bin_count  (o_bin_count),
        .o_peak_count (o_peak_count),
        .o_total_count(o_total_count)
    );

    function automatic t_time rand48();
        return t_time'({$urandom, $urandom});
    endfunction

    function automatic int unsigned active_bins();
        if (nbins == 0) return 1;
        if (nbins > HIST_BINS) return HIST_BINS;
        return 32'(nbins);
    endfunction

    function automatic hist_result_t histogram_update(hist_item_t it);
        hist_result_t r;
        logic [63:0]  n;
        logic [63:0]  span;
        logic [63:0]  bin;
        t_bin_out     idx;
        r = '0;
        if (it.mode) begin
            r.bin_index = it.read_bin;
            r.bin_count = hist_bins[it.read_bin];
        end else if (win_end > win_start && it.event_time >= win_start
                     && it.event_time <= win_end) begin
            n    = 64'(active_bins());
            span = 64'(win_end) - 64'(win_start);
            bin  = ((64'(it.event_time) - 64'(win_start)) * n) / span;
            if (bin >= n) bin = n - 1;
            idx = bin[BIN_OUT_W-1:0];
            if (hist_bins[idx] != COUNT_MAX) hist_bins[idx] = hist_bins[idx] + 1;
            if (hist_bins[idx] > hist_peak) hist_peak = hist_bins[idx];
            if (hist_total != COUNT_MAX) hist_total = hist_total + 1;
            r.in_window = 1'b1;
            r.bin_index = idx;
            r.bin_count = hist_bins[idx];
        end
        r.peak_count  = hist_peak;
        r.total_count = hist_total;
        return r;
    endfunction

    function automatic hist_item_t random_item();
        hist_item_t  it;
        logic [63:0] span;
        int          sel;
        it.mode       = ($urandom_range(99) < 18);
        it.event_time = rand48();
        it.read_bin   = t_bin_out'($urandom_range(1023));
        sel           = $urandom_range(99);
        if (it.mode) begin
            if (sel < 60) it.read_bin = t_bin_out'($urandom_range(active_bins() - 1));
        end else if (win_end > win_start) begin
            span = 64'(win_end) - 64'(win_start);
            if (sel < 70)
                it.event_time = win_start + t_time'({$urandom, $urandom} % (span + 1));
            else if (sel < 75) it.event_time = win_start;
            else if (sel < 80) it.event_time = win_end;
            else if (sel < 85) it.event_time = win_start - t_time'(1);
            else if (sel < 90) it.event_time = win_end + t_time'(1);
        end else if (sel < 60) begin
            it.event_time = win_start + t_time'($urandom_range(2)) - t_time'(1);
        end
        return it;
    endfunction

    function automatic void queue_item(logic m, t_time t, t_bin_out rb);
        pending_events.push_back({m, t, rb});
    endfunction

    task automatic cfg_write(t_cfg_idx idx, t_time val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_WINDOW_START: win_start = val;
            CFG_WINDOW_END:   win_end   = val;
            CFG_BINS_IN_USE:  nbins     = val[NBINS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_window(t_time s, t_time e, t_nbins n);
        cfg_write(CFG_WINDOW_START, s);
        cfg_write(CFG_WINDOW_END, e);
        cfg_write(CFG_BINS_IN_USE, t_time'(n));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_window();
        t_time       s;
        t_time       e;
        logic [63:0] w;
        t_nbins      n;
        int          kind;
        kind = $urandom_range(11);
        s    = rand48() >> $urandom_range(0, 47);
        w    = 64'($urandom_range(1, 1 << $urandom_range(0, 30)));
        if (kind == 4 || kind == 5) w = 64'(rand48() >> $urandom_range(0, 40)) + 1;
        e = (64'(s) + w > 64'(T_MAX)) ? T_MAX : s + t_time'(w);
        case (kind)
            0: e = s;
            1: begin
                e = rand48();
                if (e > s) {s, e} = {e, s};
            end
            2: begin
                s = '0;
                e = T_MAX;
            end
            3: begin
                e = T_MAX;
                s = T_MAX - t_time'($urandom_range(1, 5000));
            end
            default: ;
        endcase
        case ($urandom_range(9))
            0: n = '0;
            1: n = 11'd1;
            2: n = '1;
            3: n = 11'd1024;
            4: n = 11'd1025;
            5: n = t_nbins'($urandom_range(1, 2047));
            default: n = t_nbins'($urandom_range(1, 16));
        endcase
        set_window(s, e, n);
    endtask

    task automatic release_and_drain();
        @(negedge i_clk);
        feed_hold = 1'b0;
        @(negedge i_clk);
        while (pending_events.size() != 0 || start || predicted_results.size() != 0)
            @(negedge i_clk);
        feed_hold = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // driver: one beat per start/!busy edge
    always @(posedge i_clk) begin
        hist_item_t nxt;
        logic       go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predicted_results.push_back(histogram_update({i_mode, i_event_time, i_read_bin}));
            end
            if (!start || !busy) begin
                go = !feed_hold && pending_events.size() != 0
                     && $urandom_range(99) >= idle_pct;
                if (go) begin
                    nxt          = pending_events.pop_front();
                    i_mode       <= nxt.mode;
                    i_event_time <= nxt.event_time;
                    i_read_bin   <= nxt.read_bin;
                end
                start <= go;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        hist_result_t got;
        hist_result_t want;
        if (i_rst_n && o_done) begin
            got = {o_in_window, o_bin_index, o_bin_count, o_peak_count, o_total_count};
            if (predicted_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: win=%0d bin=%0d cnt=%0d peak=%0d total=%0d",
                             got.in_window, got.bin_index, got.bin_count,
                             got.peak_count, got.total_count);
            end else begin
                want = predicted_results.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch exp: win=%0d bin=%0d cnt=%0d peak=%0d total=%0d",
                                 want.in_window, want.bin_index, want.bin_count,
                                 want.peak_count, want.total_count);
                        $display("         got: win=%0d bin=%0d cnt=%0d peak=%0d total=%0d",
                                 got.in_window, got.bin_index, got.bin_count,
                                 got.peak_count, got.total_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cnt <= 0;
        end else if (stall_cnt == STALL_LIMIT) begin
            $display("FAIL windowed_time_histogram");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        int issued;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // bin store clear runs after reset
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);

        idle_pct = 32;
        queue_item(1'b0, 48'd0, '0);
        queue_item(1'b0, 48'd65536, '0);
        queue_item(1'b0, 48'd32768, '0);
        queue_item(1'b0, 48'd32768, '0);
        queue_item(1'b0, 48'd65537, '0);
        queue_item(1'b0, T_MAX, '0);
        queue_item(1'b1, '0, 10'd512);
        queue_item(1'b1, '0, 10'd1023);
        queue_item(1'b1, '0, 10'd700);
        release_and_drain();

        // empty windows: equal ends, then end before start
        set_window(48'd1000, 48'd1000, 11'd1024);
        queue_item(1'b0, 48'd1000, '0);
        release_and_drain();
        set_window(48'd5000, 48'd4000, 11'd1024);
        queue_item(1'b0, 48'd4500, '0);
        release_and_drain();

        // zero bins acts as one bin
        set_window(48'd100, 48'd200, 11'd0);
        queue_item(1'b0, 48'd150, '0);
        queue_item(1'b0, 48'd200, '0);
        release_and_drain();

        // oversized bin count, window at top of range
        set_window(T_MAX - 1, T_MAX, 11'd2047);
        queue_item(1'b0, T_MAX, '0);
        queue_item(1'b0, T_MAX - 1, '0);
        queue_item(1'b1, '0, 10'd1023);
        release_and_drain();

        set_window('0, T_MAX, 11'd1024);
        queue_item(1'b0, T_MAX, '0);
        queue_item(1'b0, 48'h8000_0000_0000, '0);
        queue_item(1'b1, '0, 10'd1023);
        release_and_drain();

        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            random_window();
            n        = (win_end > win_start) ? $urandom_range(40, 100) : 12;
            idle_pct = (issued < RANDOM_ITEMS / 3) ? 32 :
                       (issued < 2 * RANDOM_ITEMS / 3) ? 65 : 0;
            repeat (n) pending_events.push_back(random_item());
            issued += n;
            release_and_drain();
        end

        if (mismatch_cnt == 0 && predicted_results.size() == 0) begin
            $display("PASS windowed_time_histogram");
        end else begin
            $display("FAIL windowed_time_histogram");
        end
        $finish;
    end

endmodule
